@@ hdl/aes128_block_cipher_defines.svh @@
// Assertion macros shared by the AES-128 block cipher modules.
// No dependencies; included inside module bodies.
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/aes_pkg.sv @@
// Package for the AES-128 block cipher: S-box tables and GF(2^8) helpers.
// No dependencies; used by all cipher modules.
package aes_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumWords = 4 * (NumRounds + 1);
    localparam int unsigned RndW = $clog2(NumRounds + 1);
    localparam logic [7:0] MixPoly = 8'h1b;
    localparam logic [7:0] TopBit = 8'h80;

    typedef logic [7:0] byte_t;
    typedef logic [31:0] word_t;
    typedef logic [127:0] blk_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam byte_t RCON [NumRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic byte_t xtime(input byte_t a);
        xtime = {a[6:0], 1'b0} ^ (((a & TopBit) != 8'h00) ? MixPoly : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte k of a block (k = 0 in the top bits).
    function automatic byte_t blk_byte(input blk_t b, input int k);
        blk_byte = b[127 - 8 * k -: 8];
    endfunction
endpackage

@@ hdl/aes_key_cell.sv @@
// One cell of the key schedule chain: holds one round key (four words)
// and hands it to the next cell. Depends on aes_pkg.
module aes_key_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          shift_fwd,
    input  logic          shift_rev,
    input  aes_pkg::blk_t load_key,
    input  aes_pkg::blk_t from_prev,
    input  aes_pkg::blk_t from_next,
    output aes_pkg::blk_t key
);
    import aes_pkg::*;

    blk_t key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (load)
        begin
            key_reg <= load_key;
        end
        else if (shift_fwd)
        begin
            key_reg <= from_prev;
        end
        else if (shift_rev)
        begin
            key_reg <= from_next;
        end
    end

    assign key = key_reg;
endmodule

@@ hdl/aes_key_chain.sv @@
// Key schedule: a row of eleven round-key cells, filled by a one-round-a-cycle
// expander and rotated so that cell 0 (encrypt) or cell 10 (decrypt) holds the
// key of the next round. Depends on aes_pkg and aes_key_cell.
module aes_key_chain (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  aes_pkg::blk_t cipher_key,
    input  logic          rot_fwd,
    input  logic          rot_rev,
    output logic          busy,
    output aes_pkg::blk_t head_key,
    output aes_pkg::blk_t tail_key
);
    import aes_pkg::*;
    `include "aes128_block_cipher_defines.svh"

    blk_t cell_key [NumRounds + 1];
    blk_t gen_reg;
    blk_t gen_next;
    logic [RndW-1:0] cnt_reg;
    logic busy_reg;
    word_t t;

    // Expander: next round key from the current one. The count is zero only
    // while round 0 enters the chain, when the expander output is unused.
    always_comb
    begin
        t = sub_word({gen_reg[23:0], gen_reg[31:24]})
            ^ {RCON[(cnt_reg == '0) ? '0 : cnt_reg - 1'b1], 24'h0};
        gen_next[127:96] = gen_reg[127:96] ^ t;
        gen_next[95:64] = gen_reg[95:64] ^ gen_next[127:96];
        gen_next[63:32] = gen_reg[63:32] ^ gen_next[95:64];
        gen_next[31:0] = gen_reg[31:0] ^ gen_next[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
            gen_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
            gen_reg <= cipher_key;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == RndW'(NumRounds))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    gen_reg <= gen_next;
                end
            end
        end
    end

    // While filling, the chain shifts toward cell 0 with the newest key
    // entering at the tail, so after eleven shifts cell i holds round i.
    for (genvar i = 0; i <= NumRounds; i++)
    begin : g_cell
        blk_t prev_key;
        blk_t next_key;
        assign prev_key = (i == 0) ? cell_key[NumRounds] : cell_key[(i == 0) ? 0 : i - 1];
        assign next_key = (i == NumRounds) ? (busy_reg ? ((cnt_reg == '0) ? gen_reg : gen_next)
                                                       : cell_key[0])
                                           : cell_key[(i == NumRounds) ? 0 : i + 1];
        aes_key_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (1'b0),
            .shift_fwd(!busy_reg && rot_rev),
            .shift_rev((busy_reg && !start && cnt_reg != RndW'(NumRounds + 1))
                       || (!busy_reg && rot_fwd)),
            .load_key (gen_reg),
            .from_prev(prev_key),
            .from_next(next_key),
            .key      (cell_key[i])
        );
    end

    assign busy = busy_reg;
    assign head_key = cell_key[0];
    assign tail_key = cell_key[NumRounds];

    `AES_ASSERT_NEXT(a_cnt_bound, busy_reg && !start, cnt_reg <= RndW'(NumRounds),
        "key expander count out of range")
    `AES_ASSERT_IMP(a_no_rot_busy, busy_reg, !rot_fwd && !rot_rev,
        "key chain rotated during expansion")
    `AES_ASSERT_NEXT(a_start_busy, start, busy_reg, "expansion did not start")
endmodule

@@ hdl/aes_round.sv @@
// One AES round (forward or inverse) on a 128-bit state, combinational.
// Depends on aes_pkg.
module aes_round (
    input  aes_pkg::blk_t din,
    input  aes_pkg::blk_t rkey,
    input  logic          inverse,
    input  logic          last,
    output aes_pkg::blk_t dout
);
    import aes_pkg::*;

    byte_t s [16];
    byte_t sh [16];
    byte_t m [16];
    byte_t a0, a1, a2, a3;
    byte_t x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    blk_t fwd_out;
    blk_t inv_ak;
    blk_t inv_out;

    always_comb
    begin
        // Forward: SubBytes, ShiftRows, MixColumns, AddRoundKey.
        for (int i = 0; i < 16; i++)
        begin
            s[i] = SBOX[blk_byte(din, i)];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[c * 4 + r] = s[((c + r) % 4) * 4 + r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sh[c * 4]; a1 = sh[c * 4 + 1]; a2 = sh[c * 4 + 2]; a3 = sh[c * 4 + 3];
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            m[c * 4]     = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            m[c * 4 + 1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            m[c * 4 + 2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            m[c * 4 + 3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        for (int i = 0; i < 16; i++)
        begin
            fwd_out[127 - 8 * i -: 8] = (last ? sh[i] : m[i]) ^ blk_byte(rkey, i);
        end

        // Inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[((c + r) % 4) * 4 + r] = blk_byte(din, c * 4 + r);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            inv_ak[127 - 8 * i -: 8] = ISBOX[sh[i]] ^ blk_byte(rkey, i);
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = blk_byte(inv_ak, c * 4);     a1 = blk_byte(inv_ak, c * 4 + 1);
            a2 = blk_byte(inv_ak, c * 4 + 2); a3 = blk_byte(inv_ak, c * 4 + 3);
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
            z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
            // 14=8+4+2, 11=8+2+1, 13=8+4+1, 9=8+1
            inv_out[127 - 32 * c -: 8] = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1) ^ (z2 ^ y2 ^ a2) ^ (z3 ^ a3);
            inv_out[119 - 32 * c -: 8] = (z0 ^ a0) ^ (z1 ^ y1 ^ x1) ^ (z2 ^ x2 ^ a2) ^ (z3 ^ y3 ^ a3);
            inv_out[111 - 32 * c -: 8] = (z0 ^ y0 ^ a0) ^ (z1 ^ a1) ^ (z2 ^ y2 ^ x2) ^ (z3 ^ x3 ^ a3);
            inv_out[103 - 32 * c -: 8] = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1) ^ (z2 ^ a2) ^ (z3 ^ y3 ^ x3);
        end
    end

    assign dout = inverse ? (last ? inv_ak : inv_out) : fwd_out;
endmodule

@@ hdl/aes128_block_cipher.sv @@
// Top level of the AES-128 block cipher: stream ports, key configuration,
// round sequencer. Depends on aes_pkg, aes_key_chain and aes_round.
//
// Usage:
//   Configuration: write key_high at index 0 and key_low at index 1 with
//   cfg_we. Each write restarts key expansion with the new half and the held
//   other half; the input channel does not accept a transaction until all
//   eleven round keys have been expanded and loaded into the chain.
//   Input: s_axis_tdata = {block_low, block_high} over bits [127:0] and
//   s_axis_tuser = action (0 encrypt, 1 decrypt). Output: m_axis_tdata =
//   {result_low, result_high}.
//   Processing: the initial key addition is done as the block is accepted,
//   then the ten rounds run one after another, and the result is loaded into
//   the output register once that register is free. One block is in flight at
//   a time, and a new block is taken only after its predecessor's result has
//   been loaded. The round key chain rotates one cell per round.
//   After reset the all-zero key is expanded before the first transaction is
//   taken. A finished result sits in the output register until taken; while
//   it waits the next block is accepted and processed, and it finishes only
//   once the register is free.
module aes128_block_cipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // result_high [63:0], result_low [127:64]
);
    import aes_pkg::*;
    `include "aes128_block_cipher_defines.svh"

    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [63:0] key_high_reg, key_low_reg;
    logic [63:0] key_high_next, key_low_next;
    blk_t st_reg, st_next;
    logic inv_reg;
    logic [RndW-1:0] rnd_reg, rnd_next;
    blk_t out_reg;
    logic out_valid_reg;
    logic kbusy;
    blk_t head_key, tail_key, rk, rd;
    logic in_acc, out_acc, rot_f, rot_r, finish;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !kbusy;

    // The expander starts on the write edge, so it takes the key as written.
    assign key_high_next = (cfg_we && cfg_index == CfgKeyHigh) ? cfg_data : key_high_reg;
    assign key_low_next = (cfg_we && cfg_index == CfgKeyLow) ? cfg_data : key_low_reg;

    aes_key_chain u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_we),
        .cipher_key({key_high_next, key_low_next}),
        .rot_fwd   (rot_f),
        .rot_rev   (rot_r),
        .busy      (kbusy),
        .head_key  (head_key),
        .tail_key  (tail_key)
    );

    // Encryption walks the chain forward (head holds next round); decryption
    // walks it backward (tail holds next round).
    assign rk = inv_reg ? tail_key : head_key;
    aes_round u_round (
        .din    (st_reg),
        .rkey   (rk),
        .inverse(inv_reg),
        .last   (rnd_reg == RndW'(NumRounds)),
        .dout   (rd)
    );

    assign finish = (state_reg == ST_DONE) && (!out_valid_reg || out_acc);

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        rnd_next = rnd_reg;
        rot_f = 1'b0;
        rot_r = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // Initial key addition uses round 0 (encrypt) or 10 (decrypt).
                    st_next = {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                            ^ (s_axis_tuser ? tail_key : head_key);
                    rnd_next = RndW'(1);
                    rot_f = !s_axis_tuser;
                    rot_r = s_axis_tuser;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                st_next = rd;
                rnd_next = rnd_reg + 1'b1;
                rot_f = !inv_reg;
                rot_r = inv_reg;
                if (rnd_reg == RndW'(NumRounds))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_high_reg <= '0;
            key_low_reg <= '0;
            out_valid_reg <= 1'b0;
            rnd_reg <= '0;
            inv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            key_high_reg <= key_high_next;
            key_low_reg <= key_low_next;
            if (in_acc)
            begin
                inv_reg <= s_axis_tuser;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (finish)
        begin
            out_reg <= st_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_reg[63:0], out_reg[127:64]};

    `AES_ASSERT_IMP(a_ready_idle, s_axis_tready, state_reg == ST_IDLE && !kbusy,
        "input ready outside idle")
    `AES_ASSERT_NEXT(a_run_rnd, state_reg == ST_RUN, rnd_reg != '0,
        "round counter wrapped")
    `AES_ASSERT_IMP(a_done_cnt, state_reg == ST_DONE, rnd_reg == RndW'(NumRounds + 1),
        "result ready before tenth round")
endmodule

@@ tb/sv/aes128_block_cipher_test.sv @@
// Self-checking testbench for the AES-128 block cipher: encrypts and decrypts
// directed and random blocks under several keys and checks every result.
// Depends on aes_pkg (S-box tables, round constants) and aes128_block_cipher.
module aes128_block_cipher_test;
    import aes_pkg::*;

    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned ExpandCycles = 12;
    localparam int unsigned PhaseItems = 225;
    localparam bit IdxKeyHigh = 1'b0;
    localparam bit IdxKeyLow = 1'b1;
    localparam bit ActEncrypt = 1'b0;
    localparam bit ActDecrypt = 1'b1;

    class cipher_scoreboard;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        word_t round_keys [NumWords];
        blk_t result_q [$];
        int errors;

        function new();
            key_hi = '0;
            key_lo = '0;
            errors = 0;
            expand();
        endfunction

        function void expand();
            word_t t;
            round_keys[0] = key_hi[63:32];
            round_keys[1] = key_hi[31:0];
            round_keys[2] = key_lo[63:32];
            round_keys[3] = key_lo[31:0];
            for (int i = 4; i < NumWords; i++)
            begin
                t = round_keys[i - 1];
                if (i % 4 == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]}
                        ^ {RCON[i / 4 - 1], 24'h0};
                end
                round_keys[i] = round_keys[i - 4] ^ t;
            end
        endfunction

        function void write_key(bit idx, logic [63:0] val);
            if (idx == IdxKeyHigh)
                key_hi = val;
            else
                key_lo = val;
            expand();
        endfunction

        function byte_t gmul(byte_t a, byte_t b);
            byte_t p;
            p = 8'h00;
            for (int k = 0; k < 8; k++)
            begin
                if (b[0])
                    p ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
                b = b >> 1;
            end
            return p;
        endfunction

        // Byte k of the state sits at bits 127-8k; column c holds bytes 4c..4c+3.
        function blk_t round_key_xor(blk_t b, int rnd);
            for (int c = 0; c < 4; c++)
                b[127 - 32 * c -: 32] ^= round_keys[rnd * 4 + c];
            return b;
        endfunction

        function blk_t sbox_layer(blk_t b, bit inv);
            for (int k = 0; k < 16; k++)
                b[127 - 8 * k -: 8] = inv ? ISBOX[b[127 - 8 * k -: 8]]
                                          : SBOX[b[127 - 8 * k -: 8]];
            return b;
        endfunction

        function blk_t row_rotate(blk_t b, bit inv);
            blk_t o;
            int src;
            int dst;
            o = b;
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                begin
                    src = inv ? c * 4 + r : ((c + r) % 4) * 4 + r;
                    dst = inv ? ((c + r) % 4) * 4 + r : c * 4 + r;
                    b[127 - 8 * dst -: 8] = o[127 - 8 * src -: 8];
                end
            return b;
        endfunction

        function blk_t column_mix(blk_t b, bit inv);
            byte_t fwd [4];
            byte_t bwd [4];
            byte_t a [4];
            byte_t v;
            fwd = '{8'd2, 8'd3, 8'd1, 8'd1};
            bwd = '{8'd14, 8'd11, 8'd13, 8'd9};
            for (int c = 0; c < 4; c++)
            begin
                for (int k = 0; k < 4; k++)
                    a[k] = b[127 - 8 * (c * 4 + k) -: 8];
                for (int r = 0; r < 4; r++)
                begin
                    v = 8'h00;
                    for (int k = 0; k < 4; k++)
                        v ^= gmul(a[k], inv ? bwd[(k - r + 4) % 4] : fwd[(k - r + 4) % 4]);
                    b[127 - 8 * (c * 4 + r) -: 8] = v;
                end
            end
            return b;
        endfunction

        function blk_t cipher(bit act, blk_t b);
            if (act == ActEncrypt)
            begin
                b = round_key_xor(b, 0);
                for (int rnd = 1; rnd < NumRounds; rnd++)
                    b = round_key_xor(column_mix(row_rotate(sbox_layer(b, 0), 0), 0), rnd);
                b = round_key_xor(row_rotate(sbox_layer(b, 0), 0), NumRounds);
            end
            else
            begin
                b = round_key_xor(b, NumRounds);
                for (int rnd = NumRounds - 1; rnd > 0; rnd--)
                    b = column_mix(round_key_xor(sbox_layer(row_rotate(b, 1), 1), rnd), 1);
                b = round_key_xor(sbox_layer(row_rotate(b, 1), 1), 0);
            end
            return b;
        endfunction

        function void note_block(bit act, logic [63:0] hi, logic [63:0] lo);
            result_q.push_back(cipher(act, {hi, lo}));
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            blk_t want;
            if (result_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result %h %h", hi, lo);
                return;
            end
            want = result_q.pop_front();
            if (want[127:64] !== hi || want[63:0] !== lo)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result_high exp %h got %h, result_low exp %h got %h",
                             want[127:64], hi, want[63:0], lo);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [63:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;  // block_high [63:0], block_low [127:64]
    logic s_axis_tuser;          // action
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [127:0] m_axis_tdata;  // result_high [63:0], result_low [127:64]

    cipher_scoreboard sb;
    bit quiet;
    int unsigned cycles;

    aes128_block_cipher u_top (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);

    always @(posedge clk)
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_key(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_block(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64]);
        end

    task automatic send_block(bit act, logic [63:0] hi, logic [63:0] lo);
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {lo, hi};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drain all outstanding blocks so the key can change with the block idle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.result_q.size() != 0)
            @(posedge clk);
        repeat (ExpandCycles) @(posedge clk);
    endtask

    task automatic load_key(bit idx, logic [63:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_edges();
        send_block(ActEncrypt, '0, '0);
        send_block(ActDecrypt, '0, '0);
        send_block(ActEncrypt, '1, '1);
        send_block(ActDecrypt, '1, '1);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] hi;
        logic [63:0] lo;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = IdxKeyHigh;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = ActEncrypt;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        quiet = 1'b0;
        cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key is all zeros.
        send_edges();
        // Standard vector key and plaintext, its inverse, one more block.
        load_key(IdxKeyHigh, 64'h0001020304050607);
        load_key(IdxKeyLow, 64'h08090a0b0c0d0e0f);
        send_block(ActEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(ActDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(ActEncrypt, 64'h8000000000000000, 64'h0000000000000001);
        // All-ones key.
        load_key(IdxKeyHigh, '1);
        load_key(IdxKeyLow, '1);
        send_edges();
        // Only one half rewritten: the other half keeps its value.
        load_key(IdxKeyHigh, '0);
        send_edges();
        load_key(IdxKeyLow, 64'h0123456789abcdef);
        send_edges();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_key(IdxKeyHigh, rand64());
            load_key(IdxKeyLow, rand64());
            quiet = (ph == 2);
            for (int n = 0; n < PhaseItems; n++)
            begin
                hi = rand64();
                lo = rand64();
                send_block(1'($urandom_range(0, 1)), hi, lo);
            end
            quiet = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ aes128_block_cipher.f @@
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_key_cell.sv
hdl/aes_key_chain.sv
hdl/aes_round.sv
hdl/aes128_block_cipher.sv
tb/sv/aes128_block_cipher_test.sv
